// File: rtl/core/mandelbrot_escape_time_pixel_assert.svh
// Assertion helpers for the escape-time pixel block.
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_ASSERT_SVH

// Same-cycle implication.
`define MANDEL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MANDEL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/mandel_pkg.sv
`default_nettype none

package mandel_pkg;

  localparam int FracBitsDef  = 28;
  localparam int IndexBitsDef = 12;

  localparam int IterW     = 16;
  localparam int CoordW    = 32;
  localparam int IdxFieldW = 12;
  localparam int ColorW    = 8;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 32;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegMaxIter = 3'd0;
  localparam logic [CfgIdxW-1:0] RegXOrigin = 3'd1;
  localparam logic [CfgIdxW-1:0] RegXStep   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegYOrigin = 3'd3;
  localparam logic [CfgIdxW-1:0] RegYStep   = 3'd4;

  localparam logic [IterW-1:0]         MaxIterRst = 16'd1000;
  localparam logic signed [CoordW-1:0] XOriginRst = -32'sd536870912;
  localparam logic signed [CoordW-1:0] XStepRst   = 32'sd1328729;
  localparam logic signed [CoordW-1:0] YOriginRst = -32'sd300647711;
  localparam logic signed [CoordW-1:0] YStepRst   = 32'sd1205001;

  typedef struct packed {
    logic [IterW-1:0]         iter_limit;
    logic signed [CoordW-1:0] x_origin;
    logic signed [CoordW-1:0] x_step;
    logic signed [CoordW-1:0] y_origin;
    logic signed [CoordW-1:0] y_step;
  } mandel_cfg_t;

  // 5n mod 256
  function automatic logic [ColorW-1:0] green_of(input logic [ColorW-1:0] n);
    return n + (n << 2);
  endfunction

  // 13n mod 256
  function automatic logic [ColorW-1:0] blue_of(input logic [ColorW-1:0] n);
    return n + (n << 2) + (n << 3);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/mandel_cfg.sv
`default_nettype none

module mandel_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mandel_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [mandel_pkg::CfgDataW-1:0]    cfg_data_i,
  output mandel_pkg::mandel_cfg_t            cfg_o
);
  import mandel_pkg::*;

  mandel_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegMaxIter: cfg_d.iter_limit = cfg_data_i[IterW-1:0];
        RegXOrigin: cfg_d.x_origin   = $signed(cfg_data_i[CoordW-1:0]);
        RegXStep:   cfg_d.x_step     = $signed(cfg_data_i[CoordW-1:0]);
        RegYOrigin: cfg_d.y_origin   = $signed(cfg_data_i[CoordW-1:0]);
        RegYStep:   cfg_d.y_step     = $signed(cfg_data_i[CoordW-1:0]);
        default: ;  // unused index, dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.iter_limit <= MaxIterRst;
      cfg_q.x_origin   <= XOriginRst;
      cfg_q.x_step     <= XStepRst;
      cfg_q.y_origin   <= YOriginRst;
      cfg_q.y_step     <= YStepRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: rtl/core/mandel_mul.sv
`default_nettype none

// Unsigned multiplier, one digit-by-digit partial product per cycle.
// Operands are latched on start_i; done_o pulses when prod_o is final.
module mandel_mul #(
  parameter int WIDTH = 30
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [WIDTH-1:0]   a_i,
  input  logic [WIDTH-1:0]   b_i,
  output logic               done_o,
  output logic [2*WIDTH-1:0] prod_o
);
  import mandel_pkg::*;

  localparam int NumDig = (WIDTH + 31) / 32;
  localparam int DigW   = (WIDTH + NumDig - 1) / NumDig;
  localparam int PadW   = NumDig * DigW;
  localparam int AccW   = 2 * PadW;
  localparam int CntW   = (NumDig > 1) ? $clog2(NumDig) : 1;
  localparam logic [CntW-1:0] LastDig = CntW'(NumDig - 1);

  logic              busy_q, busy_d;
  logic [CntW-1:0]   ia_q, ia_d, ib_q, ib_d;
  logic              pp_vld_q, pp_last_q, done_q;
  logic [CntW:0]     pp_sh_q;
  logic [2*DigW-1:0] pp_q;
  logic [PadW-1:0]   a_q, b_q;
  logic [AccW-1:0]   acc_q;
  logic              last_pair;

  assign last_pair = (ia_q == LastDig) && (ib_q == LastDig);

  always_comb begin
    busy_d = busy_q;
    ia_d   = ia_q;
    ib_d   = ib_q;
    if (start_i) begin
      busy_d = 1'b1;
      ia_d   = '0;
      ib_d   = '0;
    end else if (busy_q) begin
      if (last_pair) begin
        busy_d = 1'b0;
      end else if (ib_q == LastDig) begin
        ib_d = '0;
        ia_d = ia_q + CntW'(1);
      end else begin
        ib_d = ib_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      ia_q      <= '0;
      ib_q      <= '0;
      pp_vld_q  <= 1'b0;
      pp_last_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      ia_q      <= ia_d;
      ib_q      <= ib_d;
      pp_vld_q  <= busy_q && !start_i;
      pp_last_q <= busy_q && !start_i && last_pair;
      done_q    <= pp_vld_q && pp_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= PadW'(a_i);
      b_q   <= PadW'(b_i);
      acc_q <= '0;
    end else if (pp_vld_q) begin
      acc_q <= acc_q + (AccW'(pp_q) << (int'(pp_sh_q) * DigW));
    end
    pp_q    <= a_q[ia_q*DigW +: DigW] * b_q[ib_q*DigW +: DigW];
    pp_sh_q <= {1'b0, ia_q} + {1'b0, ib_q};
  end

  assign done_o = done_q;
  assign prod_o = acc_q[2*WIDTH-1:0];

endmodule

`default_nettype wire

// File: rtl/core/mandelbrot_escape_time_pixel.sv
// Channel  Dir  Handshake                 Payload
// in       in   in_valid_i / in_stall_o   column_i, row_i
// out      out  out_valid_o / out_stall_i iteration_count_o, escaped_o, red_o, green_o, blue_o
// cfg      in   cfg_we_i                  cfg_index_i, cfg_data_i
//
// One request at a time. Setup runs SCx, SCy and SCadd; each iteration then
// runs STest, the products SMxx, SMyy and SMxy on the shared multiplier of
// D = ceil((FRAC_BITS+2)/32) digits (D = 1 up to FRAC_BITS 30), and SUpd. A final
// check and the output load follow; when only the |z|^2 test trips, SMyy leads to SDone.
// Reset clears the sequencer and restores the register defaults.
// in_stall_o is high whenever a request is in flight; a finished result waits
// in the output register while the next request is taken.
`default_nettype none
`include "mandelbrot_escape_time_pixel_assert.svh"

module mandelbrot_escape_time_pixel #(
  parameter int FRAC_BITS  = mandel_pkg::FracBitsDef,
  parameter int INDEX_BITS = mandel_pkg::IndexBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mandel_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [mandel_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [mandel_pkg::IdxFieldW-1:0] column_i,
  input  logic [mandel_pkg::IdxFieldW-1:0] row_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [mandel_pkg::IterW-1:0]     iteration_count_o,
  output logic                             escaped_o,
  output logic [mandel_pkg::ColorW-1:0]    red_o,
  output logic [mandel_pkg::ColorW-1:0]    green_o,
  output logic [mandel_pkg::ColorW-1:0]    blue_o
);
  import mandel_pkg::*;

  localparam int IW = (INDEX_BITS < IdxFieldW) ? INDEX_BITS : IdxFieldW;
  localparam int CW = IW + CoordW + 1;                          // c width
  localparam int ZW = ((CW > FRAC_BITS + 3) ? CW : FRAC_BITS + 3) + 2;
  localparam int MW = FRAC_BITS + 2;                            // |z| <= 2 operand
  localparam int PW = 2 * MW;

  localparam logic [ZW-1:0] Two  = ZW'(1) << (FRAC_BITS + 1);
  localparam logic [PW:0]   Four = (PW + 1)'(1) << (2 * FRAC_BITS + 2);

  localparam logic [3:0] SIdle = 4'd0;
  localparam logic [3:0] SCx   = 4'd1;
  localparam logic [3:0] SCy   = 4'd2;
  localparam logic [3:0] SCadd = 4'd3;
  localparam logic [3:0] STest = 4'd4;
  localparam logic [3:0] SMxx  = 4'd5;
  localparam logic [3:0] SMyy  = 4'd6;
  localparam logic [3:0] SMxy  = 4'd7;
  localparam logic [3:0] SUpd  = 4'd8;
  localparam logic [3:0] SDone = 4'd9;

  mandel_cfg_t cfg;

  mandel_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  logic [3:0]              state_q, state_d;
  logic                    out_valid_q, out_valid_d, load_out;
  logic [IW-1:0]           col_q, row_q;
  logic signed [CW-1:0]    cprod_q, cmul, cx_q, cy_q;
  logic signed [ZW-1:0]    x_q, y_q, diff_q, xyf_q;
  logic [PW-1:0]           xx_q;
  logic [IterW-1:0]        n_q;
  logic                    esc_q;
  logic [ZW-1:0]           mx, my, xsh, ysh, qxy;
  logic                    xy_rem, xy_neg, outside_sum, outside_mag;
  logic                    mul_start, mul_done;
  logic [MW-1:0]           mul_a, mul_b;
  logic [PW-1:0]           mul_prod;
  logic [PW:0]             sq_sum;
  logic [IterW-1:0]        cnt_q;
  logic                    esc_out_q;
  logic [ColorW-1:0]       red_q, green_q, blue_q;

  mandel_mul #(
    .WIDTH (MW)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  // index times step, shared by both coordinates
  always_comb begin
    if (state_q == SCx) begin
      cmul = $signed({1'b0, col_q}) * cfg.x_step;
    end else begin
      cmul = $signed({1'b0, row_q}) * cfg.y_step;
    end
  end

  assign mx = x_q[ZW-1] ? ZW'(-x_q) : ZW'(x_q);
  assign my = y_q[ZW-1] ? ZW'(-y_q) : ZW'(y_q);
  assign outside_mag = (mx > Two) || (my > Two);

  assign sq_sum      = {1'b0, xx_q} + {1'b0, mul_prod};
  assign outside_sum = sq_sum > Four;
  assign xsh         = ZW'(xx_q >> FRAC_BITS);
  assign ysh         = ZW'(mul_prod >> FRAC_BITS);

  // floor(2xy) with sign: -(q + r) = ~q + !r
  assign qxy    = ZW'(mul_prod >> (FRAC_BITS - 1));
  assign xy_rem = |mul_prod[FRAC_BITS-2:0];
  assign xy_neg = x_q[ZW-1] ^ y_q[ZW-1];

  always_comb begin
    mul_start = 1'b0;
    mul_a     = mx[MW-1:0];
    mul_b     = mx[MW-1:0];
    if (state_q == SMxx) begin
      mul_a = my[MW-1:0];
      mul_b = my[MW-1:0];
    end else if (state_q == SMyy) begin
      mul_b = my[MW-1:0];
    end
    unique case (state_q)
      STest:   mul_start = (n_q < cfg.iter_limit) && !outside_mag;
      SMxx:    mul_start = mul_done;
      SMyy:    mul_start = mul_done && !outside_sum;
      default: mul_start = 1'b0;
    endcase
  end

  assign load_out = (state_q == SDone) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: if (in_valid_i) state_d = SCx;
      SCx:   state_d = SCy;
      SCy:   state_d = SCadd;
      SCadd: state_d = STest;
      STest: begin
        if (n_q >= cfg.iter_limit || outside_mag) begin
          state_d = SDone;
        end else begin
          state_d = SMxx;
        end
      end
      SMxx: if (mul_done) state_d = SMyy;
      SMyy: begin
        if (mul_done) state_d = outside_sum ? SDone : SMxy;
      end
      SMxy:  if (mul_done) state_d = SUpd;
      SUpd:  state_d = STest;
      SDone: if (load_out) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  assign out_valid_d = load_out || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && in_valid_i) begin
      col_q <= column_i[IW-1:0];
      row_q <= row_i[IW-1:0];
    end
    if (state_q == SCx || state_q == SCy) begin
      cprod_q <= cmul;
    end
    if (state_q == SCy) begin
      cx_q <= CW'(cfg.x_origin) + cprod_q;
    end
    if (state_q == SCadd) begin
      cy_q <= CW'(cfg.y_origin) + cprod_q;
      x_q  <= '0;
      y_q  <= '0;
      n_q  <= '0;
    end
    if (state_q == STest) begin
      esc_q <= (n_q < cfg.iter_limit) && outside_mag;
    end
    if (state_q == SMxx && mul_done) begin
      xx_q <= mul_prod;
    end
    if (state_q == SMyy && mul_done) begin
      esc_q  <= outside_sum;
      diff_q <= $signed(xsh) - $signed(ysh);
    end
    if (state_q == SMxy && mul_done) begin
      xyf_q <= xy_neg ? $signed(~qxy + ZW'(!xy_rem)) : $signed(qxy);
    end
    if (state_q == SUpd) begin
      x_q <= diff_q + ZW'(cx_q);
      y_q <= xyf_q + ZW'(cy_q);
      n_q <= n_q + IterW'(1);
    end
    if (load_out) begin
      cnt_q     <= n_q;
      esc_out_q <= esc_q;
      red_q     <= n_q[ColorW-1:0];
      green_q   <= green_of(n_q[ColorW-1:0]);
      blue_q    <= blue_of(n_q[ColorW-1:0]);
    end
  end

  assign in_stall_o        = (state_q != SIdle);
  assign out_valid_o       = out_valid_q;
  assign iteration_count_o = cnt_q;
  assign escaped_o         = esc_out_q;
  assign red_o             = red_q;
  assign green_o           = green_q;
  assign blue_o            = blue_q;

  `MANDEL_ASSERT_IMPL(a_esc_below_limit, clk_i, rst_ni, out_valid_o && escaped_o, iteration_count_o < cfg.iter_limit, "escaped result at the limit")
  `MANDEL_ASSERT_IMPL(a_inside_at_limit, clk_i, rst_ni, out_valid_o && !escaped_o, iteration_count_o == cfg.iter_limit, "inside result short of the limit")
  `MANDEL_ASSERT_IMPL(a_upd_in_range, clk_i, rst_ni, state_q == SUpd, n_q < cfg.iter_limit, "update with count at the limit")
  `MANDEL_ASSERT_NEXT(a_upd_count, clk_i, rst_ni, state_q == SUpd, (state_q == STest) && (n_q == $past(n_q) + IterW'(1)), "count not advanced by one per update")

endmodule

`default_nettype wire

// File: sim/tb_mandelbrot_escape_time_pixel.sv
module tb_mandelbrot_escape_time_pixel;
  import mandel_pkg::*;

  localparam int FRAC = FracBitsDef;
  localparam longint RADIUS = longint'(2) << FRAC;
  localparam longint RADIUS_SQ = longint'(4) << (2 * FRAC);
  localparam int CYCLE_LIMIT = 4000000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 3000;
  localparam int RAND_PHASES = 12;
  localparam int PIXELS_PER_PHASE = 50;

  localparam logic signed [CoordW-1:0] Q_ONE = 32'sd268435456;
  localparam logic signed [CoordW-1:0] Q_TWO = 32'sd536870912;
  localparam logic signed [CoordW-1:0] Q_QUARTER = 32'sd67108864;
  localparam logic signed [CoordW-1:0] S_MAX = 32'sh7FFFFFFF;
  localparam logic signed [CoordW-1:0] S_MIN = 32'sh80000000;

  localparam mandel_cfg_t CFG_RST = '{MaxIterRst, XOriginRst, XStepRst, YOriginRst, YStepRst};

  typedef struct packed {
    logic [IterW-1:0]  count;
    logic              escaped;
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
  } pixel_t;

  typedef struct {
    mandel_cfg_t        cfg;
    logic [IdxFieldW-1:0] col;
    logic [IdxFieldW-1:0] row;
    bit                 typed;
    logic [IterW-1:0]   want_n;
    bit                 want_esc;
  } probe_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [IdxFieldW-1:0] column_i = '0;
  logic [IdxFieldW-1:0] row_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [IterW-1:0]     iteration_count_o;
  logic                 escaped_o;
  logic [ColorW-1:0]    red_o;
  logic [ColorW-1:0]    green_o;
  logic [ColorW-1:0]    blue_o;

  mandelbrot_escape_time_pixel uut (.*);

  mandel_cfg_t live_cfg = CFG_RST;
  pixel_t      awaited_pixels[$];
  probe_t      probes[$];
  int          errors = 0;
  int          cycles = 0;
  bit          calm = 1'b0;
  bit          squeeze_req = 1'b0;
  bit          squeeze_done = 1'b0;
  int          hold_left = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic pixel_t shade(input logic [IterW-1:0] n, input bit esc);
    pixel_t p;
    logic [ColorW-1:0] nb;
    nb = n[ColorW-1:0];
    p.count = n;
    p.escaped = esc;
    p.red = nb;
    p.green = nb * 8'd5;
    p.blue = nb * 8'd13;
    return p;
  endfunction

  // z = z*z + c with floor-rounded products; escape when |x| or |y| > 2 or |z|^2 > 4
  function automatic pixel_t escape_time(input mandel_cfg_t cfg,
                                         input logic [IdxFieldW-1:0] col,
                                         input logic [IdxFieldW-1:0] row);
    longint cx, cy, x, y, nx, ny, mx, my;
    int unsigned n;
    bit esc;
    cx = longint'(cfg.x_origin) + longint'({1'b0, col}) * longint'(cfg.x_step);
    cy = longint'(cfg.y_origin) + longint'({1'b0, row}) * longint'(cfg.y_step);
    x = 0;
    y = 0;
    n = 0;
    esc = 1'b0;
    while (n < cfg.iter_limit) begin
      mx = (x < 0) ? -x : x;
      my = (y < 0) ? -y : y;
      if (mx > RADIUS || my > RADIUS || mx * mx + my * my > RADIUS_SQ) begin
        esc = 1'b1;
        break;
      end
      nx = ((x * x) >>> FRAC) - ((y * y) >>> FRAC) + cx;
      ny = ((x * y) >>> (FRAC - 1)) + cy;
      x = nx;
      y = ny;
      n++;
    end
    return shade(n[IterW-1:0], esc);
  endfunction

  function automatic void store_reg(input logic [CfgIdxW-1:0] idx,
                                    input logic [CfgDataW-1:0] data);
    case (idx)
      RegMaxIter: live_cfg.iter_limit = data[IterW-1:0];
      RegXOrigin: live_cfg.x_origin = data;
      RegXStep:   live_cfg.x_step = data;
      RegYOrigin: live_cfg.y_origin = data;
      RegYStep:   live_cfg.y_step = data;
      default: ;
    endcase
  endfunction

  function automatic void add_probe(input mandel_cfg_t cfg, input int col, input int row,
                                    input bit typed, input int n, input bit esc);
    probe_t p;
    p.cfg = cfg;
    p.col = col[IdxFieldW-1:0];
    p.row = row[IdxFieldW-1:0];
    p.typed = typed;
    p.want_n = n[IterW-1:0];
    p.want_esc = esc;
    probes.insert(probes.size(), p);
  endfunction

  // writes every index, the unused ones with junk that must be ignored
  task automatic apply_settings(input mandel_cfg_t s);
    logic [CfgIdxW-1:0] idx;
    logic [CfgDataW-1:0] word;
    for (int i = 0; i < (1 << CfgIdxW); i++) begin
      idx = i[CfgIdxW-1:0];
      case (idx)
        RegMaxIter: word = {16'($urandom), s.iter_limit};
        RegXOrigin: word = s.x_origin;
        RegXStep:   word = s.x_step;
        RegYOrigin: word = s.y_origin;
        RegYStep:   word = s.y_step;
        default:    word = $urandom;
      endcase
      cfg_we_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i <= word;
      store_reg(idx, word);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (awaited_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic offer_pixel(input logic [IdxFieldW-1:0] col, input logic [IdxFieldW-1:0] row,
                             input bit typed, input pixel_t want);
    int gap;
    gap = (!calm && $urandom_range(0, 99) < 20) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    column_i <= col;
    row_i <= row;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    awaited_pixels.insert(awaited_pixels.size(),
                          typed ? want : escape_time(live_cfg, col, row));
  endtask

  always @(posedge clk_i) begin : sink
    pixel_t want;
    if (out_valid_o && !out_stall_i) begin
      if (awaited_pixels.size() == 0) begin
        $display("%0t: result with no request pending, count %0d", $time, iteration_count_o);
        errors++;
      end else begin
        want = awaited_pixels.pop_front();
        if (iteration_count_o !== want.count) begin
          $display("%0t: iteration_count expected %0d actual %0d", $time, want.count,
                   iteration_count_o);
          errors++;
        end
        if (escaped_o !== want.escaped) begin
          $display("%0t: escaped expected %0d actual %0d", $time, want.escaped, escaped_o);
          errors++;
        end
        if (red_o !== want.red) begin
          $display("%0t: red expected %0d actual %0d", $time, want.red, red_o);
          errors++;
        end
        if (green_o !== want.green) begin
          $display("%0t: green expected %0d actual %0d", $time, want.green, green_o);
          errors++;
        end
        if (blue_o !== want.blue) begin
          $display("%0t: blue expected %0d actual %0d", $time, want.blue, blue_o);
          errors++;
        end
      end
    end
    // one long hold-off so the block backs up into its input
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (squeeze_req && !squeeze_done) begin
      squeeze_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(0, 99) < 20);
    end
  end

  initial begin
    mandel_cfg_t s;
    int g;
    int cap;
    logic [IdxFieldW-1:0] col;
    logic [IdxFieldW-1:0] row;

    add_probe(CFG_RST, 0, 0, 1, 1, 1);
    add_probe(CFG_RST, 4095, 4095, 1, 1, 1);
    add_probe(CFG_RST, 404, 250, 0, 0, 0);
    add_probe(CFG_RST, 300, 100, 0, 0, 0);
    // zero limit: no iteration at all
    add_probe('{16'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 0, 0, 1, 0, 0);
    add_probe('{16'd0, S_MAX, S_MAX, S_MAX, S_MAX}, 4095, 4095, 1, 0, 0);
    // limit reached wins over a point already outside
    add_probe('{16'd1, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 17, 3000, 1, 1, 0);
    add_probe('{16'd1, S_MAX, 32'sd0, 32'sd0, 32'sd0}, 0, 0, 1, 1, 0);
    add_probe('{16'd2, S_MAX, 32'sd0, 32'sd0, 32'sd0}, 0, 0, 1, 1, 1);
    add_probe('{16'hFFFF, S_MAX, S_MAX, S_MAX, S_MAX}, 4095, 4095, 1, 1, 1);
    add_probe('{16'hFFFF, S_MAX, S_MAX, S_MAX, S_MAX}, 0, 0, 1, 1, 1);
    add_probe('{16'hFFFF, S_MIN, S_MIN, S_MIN, S_MIN}, 4095, 0, 1, 1, 1);
    add_probe('{16'hFFFF, S_MIN, S_MIN, S_MIN, S_MIN}, 0, 4095, 1, 1, 1);
    add_probe('{16'hFFFF, S_MIN, S_MAX, S_MAX, S_MIN}, 2048, 1, 1, 1, 1);
    // c = -2 sits on the radius forever; c = 2 leaves on the second step
    add_probe('{16'd20, -Q_TWO, 32'sd0, 32'sd0, 32'sd0}, 123, 456, 1, 20, 0);
    add_probe('{16'd20, Q_TWO, 32'sd0, 32'sd0, 32'sd0}, 0, 0, 1, 2, 1);
    add_probe('{16'd100, 32'sd0, 32'sd0, Q_ONE, 32'sd0}, 0, 0, 0, 0, 0);
    add_probe('{16'd1000, Q_QUARTER, 32'sd0, 32'sd0, 32'sd0}, 0, 0, 0, 0, 0);
    add_probe('{16'd1000, Q_QUARTER + 32'sd2684354, 32'sd0, 32'sd0, 32'sd0}, 0, 0, 0, 0, 0);
    add_probe('{16'd300, Q_QUARTER, -32'sd262144, -Q_ONE, 32'sd131072}, 1000, 2048, 0, 0, 0);
    add_probe('{16'd300, Q_QUARTER, -32'sd262144, -Q_ONE, 32'sd131072}, 4095, 4095, 0, 0, 0);
    add_probe('{16'd300, Q_QUARTER, -32'sd262144, -Q_ONE, 32'sd131072}, 0, 0, 0, 0, 0);
    add_probe(CFG_RST, 404, 300, 0, 0, 0);
    add_probe(CFG_RST, 1, 4094, 0, 0, 0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (probes[i]) begin
      if (probes[i].cfg != live_cfg) begin
        wait_idle();
        apply_settings(probes[i].cfg);
      end
      offer_pixel(probes[i].col, probes[i].row, probes[i].typed,
                  shade(probes[i].want_n, probes[i].want_esc));
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      g = $urandom_range(8, 4095);
      if (ph % 5 == 4) begin
        // noise: arbitrary window, almost every point escapes at once
        s.iter_limit = $urandom_range(1, 255);
        s.x_origin = $urandom;
        s.x_step = $urandom;
        s.y_origin = $urandom;
        s.y_step = $urandom;
      end else begin
        // a g x g grid over the interesting part of the plane
        cap = (ph % 4 == 3) ? 256 : 64;
        s.iter_limit = $urandom_range(1, cap);
        s.x_step = 738197504 / g;
        s.x_origin = -603979776 + int'($urandom_range(0, 2097152)) - 1048576;
        s.y_step = 671088640 / g;
        s.y_origin = -335544320 + int'($urandom_range(0, 2097152)) - 1048576;
        if ($urandom_range(0, 1) == 1) begin
          s.y_step = -s.y_step;
          s.y_origin = -s.y_origin;
        end
      end
      wait_idle();
      calm = (ph == 6 || ph == 7);
      if (ph == 2) squeeze_req = 1'b1;
      apply_settings(s);
      repeat (PIXELS_PER_PHASE) begin
        if (ph % 5 == 4 || $urandom_range(0, 9) == 0) begin
          col = $urandom_range(0, 4095);
          row = $urandom_range(0, 4095);
        end else begin
          col = $urandom_range(0, g - 1);
          row = $urandom_range(0, g - 1);
        end
        offer_pixel(col, row, 1'b0, '0);
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
